### sv/tmee_pkg.sv
// ---------------------------------------------------------------------------
// Tile map edge extractor package
// Payload structs, link record, action and register codes, grid constants.
// ---------------------------------------------------------------------------
`default_nettype none

package tmee_pkg;

  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int MAX_EDGES = 4096;
  localparam int CELL_AW   = 12;  // row and column packed into one address
  localparam int EDGE_AW   = 12;

  localparam logic [1:0] ACT_MARK    = 2'd0;
  localparam logic [1:0] ACT_CONVERT = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] REG_X = 2'd0;
  localparam logic [1:0] REG_Y = 2'd1;
  localparam logic [1:0] REG_W = 2'd2;
  localparam logic [1:0] REG_H = 2'd3;

  localparam logic [1:0] SIDE_W = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_N = 2'd2;
  localparam logic [1:0] SIDE_S = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [11:0] edge_index;
  } in_t;

  typedef struct packed {
    logic [12:0] edge_count;
    logic        overflow;
    logic        edge_valid;
    logic [6:0]  start_x;
    logic [6:0]  start_y;
    logic [6:0]  end_x;
    logic [6:0]  end_y;
  } out_t;

  // a: west or north edge, b: east or south edge
  typedef struct packed {
    logic        va;
    logic [11:0] ida;
    logic        vb;
    logic [11:0] idb;
  } link_t;

endpackage

`default_nettype wire

### sv/tmee_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tmee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/tile_map_edge_extractor_top.sv
// ---------------------------------------------------------------------------
// Tile map edge extractor
// Bitmap of solid cells, region to edge conversion, edge table read-back.
// ---------------------------------------------------------------------------
// Mark and read pass S_MARK or S_RDE before S_DONE loads the result register;
// action 3 goes to S_DONE. Convert, per interior cell: 5 tile reads through the
// single tile RAM read port, a side state each writing the edge table for an
// exposed side with room, then link update. One item at a time; the next is
// taken while the result waits at the output. After reset a clearing pass
// empties the tile RAM; no item is taken meanwhile, configuration writes are.
`default_nettype none

module tile_map_edge_extractor_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tmee_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tmee_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [6:0]     cfg_wdata
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_MARK   = 9'b000000100,
    S_RDE    = 9'b000001000,
    S_CSTART = 9'b000010000,
    S_RD     = 9'b000100000,
    S_SIDE   = 9'b001000000,
    S_CEND   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [5:0]  rx_r, ry_r;
  logic [6:0]  rw_r, rh_r;
  logic [11:0] clr_r, clr_nxt;
  tmee_pkg::in_t item_r, item_nxt;
  logic [12:0] total_r, total_nxt;
  logic        ovf_r, ovf_nxt;
  logic [5:0]  x_r, x_nxt, y_r, y_nxt, wl_r, wl_nxt, hl_r, hl_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  side_r, side_nxt;
  logic [4:0]  nb_r, nb_nxt;  // centre, west, east, north, south
  tmee_pkg::link_t up_r, up_nxt, left_r, left_nxt, cv_r, cv_nxt, ch_r, ch_nxt;
  logic [63:0] pval_r, pval_nxt;
  logic        out_valid_r, out_valid_nxt;
  tmee_pkg::out_t out_data_r, out_data_nxt;

  // memory ports
  logic                tile_we, tile_wd;
  logic [11:0]         tile_wa, tile_ra;
  logic [0:0]          tile_q;
  logic                pcol_we;
  tmee_pkg::link_t     pcol_q;
  logic                st_we, en_we;
  logic [11:0]         en_wa, edge_ra;
  logic [13:0]         st_wd, en_wd, st_q, en_q;

  logic [5:0] gx, gy;
  logic [6:0] gx1, gy1, cw, ch_clip, w_clip, h_clip;

  assign gx  = rx_r + x_r;
  assign gy  = ry_r + y_r;
  assign gx1 = {1'b0, gx} + 7'd1;
  assign gy1 = {1'b0, gy} + 7'd1;
  assign cw      = 7'(tmee_pkg::GRID_W) - {1'b0, rx_r};
  assign ch_clip = 7'(tmee_pkg::GRID_H) - {1'b0, ry_r};
  assign w_clip  = (rw_r > cw) ? cw : rw_r;
  assign h_clip  = (rh_r > ch_clip) ? ch_clip : rh_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tmee_ram #(.WIDTH(1), .DEPTH(tmee_pkg::GRID_W * tmee_pkg::GRID_H)) u_tile (
    .clk(clk), .we(tile_we), .waddr(tile_wa), .wdata(tile_wd),
    .raddr(tile_ra), .rdata(tile_q)
  );

  tmee_ram #(.WIDTH($bits(tmee_pkg::link_t)), .DEPTH(tmee_pkg::GRID_H)) u_pcol (
    .clk(clk), .we(pcol_we), .waddr(y_r), .wdata(ch_r),
    .raddr(y_r), .rdata(pcol_q)
  );

  tmee_ram #(.WIDTH(14), .DEPTH(tmee_pkg::MAX_EDGES)) u_start (
    .clk(clk), .we(st_we), .waddr(en_wa), .wdata(st_wd),
    .raddr(edge_ra), .rdata(st_q)
  );

  tmee_ram #(.WIDTH(14), .DEPTH(tmee_pkg::MAX_EDGES)) u_end (
    .clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd),
    .raddr(edge_ra), .rdata(en_q)
  );

  assign edge_ra = item_r.edge_index;
  assign pcol_we = (state_r == S_CEND);

  // side selection
  logic        s_act, s_ext;
  logic [11:0] s_id;
  logic [6:0]  s_sx, s_sy, s_ex, s_ey;

  always_comb begin
    s_act = 1'b0;
    s_ext = 1'b0;
    s_id  = '0;
    s_sx  = {1'b0, gx};
    s_sy  = {1'b0, gy};
    s_ex  = gx1;
    s_ey  = gy1;
    unique case (side_r)
      tmee_pkg::SIDE_W: begin
        s_act = nb_r[0] & ~nb_r[1];
        s_ext = up_r.va;
        s_id  = up_r.ida;
        s_ex  = {1'b0, gx};
      end
      tmee_pkg::SIDE_E: begin
        s_act = nb_r[0] & ~nb_r[2];
        s_ext = up_r.vb;
        s_id  = up_r.idb;
        s_sx  = gx1;
      end
      tmee_pkg::SIDE_N: begin
        s_act = nb_r[0] & ~nb_r[3];
        s_ext = left_r.va;
        s_id  = left_r.ida;
        s_ey  = {1'b0, gy};
      end
      default: begin
        s_act = nb_r[0] & ~nb_r[4];
        s_ext = left_r.vb;
        s_id  = left_r.idb;
        s_sy  = gy1;
      end
    endcase
  end

  logic        res_v;
  logic [11:0] res_id;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    wl_nxt        = wl_r;
    hl_nxt        = hl_r;
    k_nxt         = k_r;
    side_nxt      = side_r;
    nb_nxt        = nb_r;
    up_nxt        = up_r;
    left_nxt      = left_r;
    cv_nxt        = cv_r;
    ch_nxt        = ch_r;
    pval_nxt      = pval_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tile_we       = 1'b0;
    tile_wd       = 1'b0;
    tile_wa       = clr_r;
    tile_ra       = {gy, gx};
    st_we         = 1'b0;
    en_we         = 1'b0;
    en_wa         = s_id;
    st_wd         = {s_sx, s_sy};
    en_wd         = {s_ex, s_ey};
    res_v         = 1'b0;
    res_id        = s_id;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        tile_we = 1'b1;
        clr_nxt = clr_r + 12'd1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          unique case (in_data.action)
            tmee_pkg::ACT_MARK:    state_nxt = S_MARK;
            tmee_pkg::ACT_CONVERT: state_nxt = S_CSTART;
            tmee_pkg::ACT_READ:    state_nxt = S_RDE;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_MARK: begin
        tile_we   = 1'b1;
        tile_wd   = 1'b1;
        tile_wa   = {item_r.cell_y, item_r.cell_x};
        state_nxt = S_DONE;
      end
      S_RDE: begin
        state_nxt = S_DONE;
      end
      S_CSTART: begin
        total_nxt = '0;
        ovf_nxt   = 1'b0;
        pval_nxt  = '0;
        x_nxt     = 6'd1;
        y_nxt     = 6'd1;
        k_nxt     = '0;
        up_nxt    = '0;
        wl_nxt    = 6'(w_clip - 7'd2);
        hl_nxt    = 6'(h_clip - 7'd2);
        if (w_clip < 7'd3 || h_clip < 7'd3) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        unique case (k_r)
          3'd0:    tile_ra = {gy, gx};
          3'd1:    tile_ra = {gy, gx - 6'd1};
          3'd2:    tile_ra = {gy, gx + 6'd1};
          3'd3:    tile_ra = {gy - 6'd1, gx};
          default: tile_ra = {gy + 6'd1, gx};
        endcase
        if (k_r != 3'd0) begin
          nb_nxt[3'(k_r - 3'd1)] = tile_q[0];
        end
        if (k_r == 3'd1) begin
          left_nxt = pval_r[y_r] ? pcol_q : '0;
        end
        cv_nxt = '0;
        ch_nxt = '0;
        k_nxt  = k_r + 3'd1;
        if (k_r == 3'd5) begin
          side_nxt  = tmee_pkg::SIDE_W;
          state_nxt = S_SIDE;
        end
      end
      S_SIDE: begin
        if (s_act) begin
          if (s_ext) begin
            en_we = 1'b1;
            res_v = 1'b1;
          end else if (total_r < 13'(tmee_pkg::MAX_EDGES)) begin
            st_we     = 1'b1;
            en_we     = 1'b1;
            en_wa     = total_r[11:0];
            res_v     = 1'b1;
            res_id    = total_r[11:0];
            total_nxt = total_r + 13'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        unique case (side_r)
          tmee_pkg::SIDE_W: begin cv_nxt.va = res_v; cv_nxt.ida = res_id; end
          tmee_pkg::SIDE_E: begin cv_nxt.vb = res_v; cv_nxt.idb = res_id; end
          tmee_pkg::SIDE_N: begin ch_nxt.va = res_v; ch_nxt.ida = res_id; end
          default:          begin ch_nxt.vb = res_v; ch_nxt.idb = res_id; end
        endcase
        side_nxt = side_r + 2'd1;
        if (side_r == tmee_pkg::SIDE_S) begin
          state_nxt = S_CEND;
        end
      end
      S_CEND: begin
        // link row for the next column, link cell for the one below
        pval_nxt[y_r] = 1'b1;
        up_nxt        = cv_r;
        k_nxt         = '0;
        state_nxt     = S_RD;
        if (y_r == hl_r) begin
          y_nxt  = 6'd1;
          up_nxt = '0;
          x_nxt  = x_r + 6'd1;
          if (x_r == wl_r) begin
            state_nxt = S_DONE;
          end
        end else begin
          y_nxt = y_r + 6'd1;
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.edge_count = total_r;
          out_data_nxt.overflow   = ovf_r;
          if (item_r.action == tmee_pkg::ACT_READ &&
              {1'b0, item_r.edge_index} < total_r) begin
            out_data_nxt.edge_valid = 1'b1;
            out_data_nxt.start_x    = st_q[13:7];
            out_data_nxt.start_y    = st_q[6:0];
            out_data_nxt.end_x      = en_q[13:7];
            out_data_nxt.end_y      = en_q[6:0];
          end
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pval_r      <= '0;
      rx_r        <= '0;
      ry_r        <= '0;
      rw_r        <= 7'd64;
      rh_r        <= 7'd64;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      pval_r      <= pval_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          tmee_pkg::REG_X: rx_r <= cfg_wdata[5:0];
          tmee_pkg::REG_Y: ry_r <= cfg_wdata[5:0];
          tmee_pkg::REG_W: rw_r <= cfg_wdata;
          default:         rh_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    wl_r       <= wl_nxt;
    hl_r       <= hl_nxt;
    k_r        <= k_nxt;
    side_r     <= side_nxt;
    nb_r       <= nb_nxt;
    up_r       <= up_nxt;
    left_r     <= left_nxt;
    cv_r       <= cv_nxt;
    ch_r       <= ch_nxt;
    out_data_r <= out_data_nxt;
  end

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 13'(tmee_pkg::MAX_EDGES))
    else $error("edge total past table size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> total_r == 13'(tmee_pkg::MAX_EDGES))
    else $error("overflow flagged with room left");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion state");

endmodule

`default_nettype wire

### sim/tb_tile_map_edge_extractor_top.sv
// ---------------------------------------------------------------------------
// Tile map edge extractor testbench
// Drives marks, region conversions and edge reads through the input channel,
// predicts every status and edge result in step with the block, and compares
// each transfer on the result channel. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_tile_map_edge_extractor_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tmee_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tmee_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [6:0] cfg_wdata = '0;

  tile_map_edge_extractor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor state
  logic       solid_map [tmee_pkg::GRID_H][tmee_pkg::GRID_W];
  logic [6:0] tbl_sx [tmee_pkg::MAX_EDGES];
  logic [6:0] tbl_sy [tmee_pkg::MAX_EDGES];
  logic [6:0] tbl_ex [tmee_pkg::MAX_EDGES];
  logic [6:0] tbl_ey [tmee_pkg::MAX_EDGES];
  int unsigned n_edges;
  logic        lost_edges;
  int unsigned reg_rx, reg_ry, reg_rw, reg_rh;
  tmee_pkg::link_t col_links [tmee_pkg::GRID_H];

  tmee_pkg::in_t  pending_items [$];
  tmee_pkg::out_t expected_out [$];
  int   errors = 0;
  int   n_queued = 0;
  int   n_converts = 0, n_reads_hit = 0, n_overflows = 0;

  function automatic bit add_unit(int sx, int sy, int ex, int ey, output logic [11:0] id);
    if (n_edges >= tmee_pkg::MAX_EDGES) begin
      lost_edges = 1'b1;
      return 1'b0;
    end
    tbl_sx[n_edges] = sx[6:0];
    tbl_sy[n_edges] = sy[6:0];
    tbl_ex[n_edges] = ex[6:0];
    tbl_ey[n_edges] = ey[6:0];
    id = n_edges[11:0];
    n_edges++;
    return 1'b1;
  endfunction

  function automatic void run_convert();
    int w, h, gx, gy;
    tmee_pkg::link_t up, left, cv, ch;
    w = 0;
    h = 0;
    if (reg_rx < tmee_pkg::GRID_W)
      w = (reg_rw > tmee_pkg::GRID_W - reg_rx) ? tmee_pkg::GRID_W - reg_rx : reg_rw;
    if (reg_ry < tmee_pkg::GRID_H)
      h = (reg_rh > tmee_pkg::GRID_H - reg_ry) ? tmee_pkg::GRID_H - reg_ry : reg_rh;
    n_edges = 0;
    lost_edges = 1'b0;
    foreach (col_links[i]) col_links[i] = '0;
    if (w < 3 || h < 3) return;
    for (int x = 1; x + 1 < w; x++) begin
      gx = reg_rx + x;
      up = '0;
      for (int y = 1; y + 1 < h; y++) begin
        gy = reg_ry + y;
        left = col_links[y];
        cv = '0;
        ch = '0;
        if (solid_map[gy][gx]) begin
          if (!solid_map[gy][gx-1]) begin
            if (up.va) begin
              tbl_ey[up.ida]++;
              cv.va = 1'b1; cv.ida = up.ida;
            end else cv.va = add_unit(gx, gy, gx, gy + 1, cv.ida);
          end
          if (!solid_map[gy][gx+1]) begin
            if (up.vb) begin
              tbl_ey[up.idb]++;
              cv.vb = 1'b1; cv.idb = up.idb;
            end else cv.vb = add_unit(gx + 1, gy, gx + 1, gy + 1, cv.idb);
          end
          if (!solid_map[gy-1][gx]) begin
            if (left.va) begin
              tbl_ex[left.ida]++;
              ch.va = 1'b1; ch.ida = left.ida;
            end else ch.va = add_unit(gx, gy, gx + 1, gy, ch.ida);
          end
          if (!solid_map[gy+1][gx]) begin
            if (left.vb) begin
              tbl_ex[left.idb]++;
              ch.vb = 1'b1; ch.idb = left.idb;
            end else ch.vb = add_unit(gx, gy + 1, gx + 1, gy + 1, ch.idb);
          end
        end
        up = cv;
        col_links[y] = ch;
      end
    end
  endfunction

  function automatic tmee_pkg::out_t predict_result(tmee_pkg::in_t it);
    tmee_pkg::out_t r;
    r = '0;
    case (it.action)
      tmee_pkg::ACT_MARK: solid_map[it.cell_y][it.cell_x] = 1'b1;
      tmee_pkg::ACT_CONVERT: begin
        run_convert();
        n_converts++;
        if (lost_edges) n_overflows++;
      end
      tmee_pkg::ACT_READ:
        if (it.edge_index < n_edges) begin
          r.edge_valid = 1'b1;
          r.start_x = tbl_sx[it.edge_index];
          r.start_y = tbl_sy[it.edge_index];
          r.end_x = tbl_ex[it.edge_index];
          r.end_y = tbl_ey[it.edge_index];
          n_reads_hit++;
        end
      default: ;
    endcase
    r.edge_count = n_edges[12:0];
    r.overflow = lost_edges;
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_out = {expected_out, predict_result(in_data)};
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    tmee_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $realtime, out_data);
        end else begin
          want = expected_out.pop_front();
          if (want !== out_data) begin
            errors++;
            $display("%0t mismatch: expected cnt=%0d ovf=%0b v=%0b (%0d,%0d)-(%0d,%0d)",
                     $realtime, want.edge_count, want.overflow, want.edge_valid,
                     want.start_x, want.start_y, want.end_x, want.end_y);
            $display("%0t           actual cnt=%0d ovf=%0b v=%0b (%0d,%0d)-(%0d,%0d)",
                     $realtime, out_data.edge_count, out_data.overflow, out_data.edge_valid,
                     out_data.start_x, out_data.start_y, out_data.end_x, out_data.end_y);
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else out_ready <= 1'b1;
    end
  end

  function automatic tmee_pkg::in_t mk(logic [1:0] a, int x, int y, int idx);
    tmee_pkg::in_t it;
    it.action = a;
    it.cell_x = x[5:0];
    it.cell_y = y[5:0];
    it.edge_index = idx[11:0];
    return it;
  endfunction

  // append to the pending queue and count it
  task automatic queue_item(tmee_pkg::in_t it);
    pending_items = {pending_items, it};
    n_queued++;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[6:0];
    case (idx)
      tmee_pkg::REG_X: reg_rx = val & 'h3f;
      tmee_pkg::REG_Y: reg_ry = val & 'h3f;
      tmee_pkg::REG_W: reg_rw = val & 'h7f;
      default: reg_rh = val & 'h7f;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the block is drained, then let a slow conversion settle
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_region(int x, int y, int w, int h);
    drain();
    write_reg(tmee_pkg::REG_X, x);
    write_reg(tmee_pkg::REG_Y, y);
    write_reg(tmee_pkg::REG_W, w);
    write_reg(tmee_pkg::REG_H, h);
  endtask

  // a batch: marks clustered around a spot with some random items, a conversion, then reads
  task automatic queue_batch(int n_marks, int n_reads);
    int cx, cy;
    cx = $urandom_range(0, 63);
    cy = $urandom_range(0, 63);
    for (int i = 0; i < n_marks; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
      else
        queue_item(mk(tmee_pkg::ACT_MARK, (cx + $urandom_range(0, 10)) % 64,
                      (cy + $urandom_range(0, 10)) % 64, 0));
    end
    queue_item(mk(tmee_pkg::ACT_CONVERT, $urandom, $urandom, $urandom));
    for (int i = 0; i < n_reads; i++) begin
      if ($urandom_range(0, 7) == 0)
        queue_item(mk(tmee_pkg::ACT_READ, 0, 0, $urandom));
      else
        queue_item(mk(tmee_pkg::ACT_READ, $urandom, $urandom,
                      $urandom_range(0, n_edges + 8)));
    end
  endtask

  initial begin
    foreach (solid_map[r, c]) solid_map[r][c] = 1'b0;
    foreach (tbl_sx[i]) begin
      tbl_sx[i] = '0; tbl_sy[i] = '0; tbl_ex[i] = '0; tbl_ey[i] = '0;
    end
    n_edges = 0;
    lost_edges = 1'b0;
    reg_rx = 0; reg_ry = 0; reg_rw = 64; reg_rh = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, extremes, every action, lone block and border cells
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    queue_item(mk(tmee_pkg::ACT_READ, 0, 0, 0));
    queue_item(mk(ACT_UNUSED, 63, 63, 4095));
    queue_item(mk(tmee_pkg::ACT_MARK, 0, 0, 4095));
    queue_item(mk(tmee_pkg::ACT_MARK, 63, 63, 0));
    queue_item(mk(tmee_pkg::ACT_MARK, 5, 5, 0));
    queue_item(mk(tmee_pkg::ACT_MARK, 5, 6, 0));
    queue_item(mk(tmee_pkg::ACT_MARK, 6, 5, 0));
    queue_item(mk(tmee_pkg::ACT_MARK, 6, 6, 0));
    queue_item(mk(tmee_pkg::ACT_MARK, 1, 62, 0));
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    for (int i = 0; i < 7; i++) queue_item(mk(tmee_pkg::ACT_READ, 0, 0, i));
    queue_item(mk(tmee_pkg::ACT_READ, 63, 63, 4095));
    queue_item(mk(ACT_UNUSED, 0, 0, 0));

    // narrow and off-grid regions yield nothing
    set_region(4, 4, 2, 64);
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    set_region(63, 63, 127, 127);
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    set_region(0, 0, 0, 0);
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));

    // overflow: isolated cells on a checkerboard over rows 1 to 36 give
    // four unit edges each, well over MAX_EDGES
    set_region(0, 0, 64, 64);
    for (int r = 1; r <= 36; r++)
      for (int c = 2 - (r & 1); c < 63; c += 2)
        queue_item(mk(tmee_pkg::ACT_MARK, c, r, 0));
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    queue_item(mk(tmee_pkg::ACT_READ, 0, 0, 4095));
    queue_item(mk(tmee_pkg::ACT_READ, 0, 0, 0));
    for (int i = 0; i < 20; i++)
      queue_item(mk(tmee_pkg::ACT_READ, 0, 0, $urandom));
    set_region(7, 3, 64, 30);
    queue_item(mk(tmee_pkg::ACT_CONVERT, 0, 0, 0));
    for (int i = 0; i < 20; i++)
      queue_item(mk(tmee_pkg::ACT_READ, 0, 0, $urandom_range(0, 500)));

    // random phases over varied regions, mostly small
    while (n_queued < 1880) begin
      case ($urandom_range(0, 5))
        0: set_region(0, 0, 64, 64);
        1: set_region($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 127),
                      $urandom_range(0, 127));
        default: set_region($urandom_range(0, 56), $urandom_range(0, 56), $urandom_range(3, 14),
                            $urandom_range(3, 14));
      endcase
      for (int b = 0; b < 3; b++) begin
        queue_batch($urandom_range(2, 30), $urandom_range(4, 20));
      end
    end
    drain();
    repeat (60) @(posedge clk);

    $display("Covered %0d items: %0d conversions (%0d overflowing), %0d edge reads that hit.",
             n_queued, n_converts, n_overflows, n_reads_hit);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_out.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
